// ===== hdl/u2k_pkg.sv =====
// Shared types and constants for the UTF-8 to single-byte kana converter.
package u2k_pkg;

	localparam logic [15:0] KANA_LO   = 16'hFF61;
	localparam logic [15:0] KANA_HI   = 16'hFF9F;
	localparam logic [15:0] KANA_BASE = 16'hFEC0;
	localparam logic [7:0]  LEAD3_PAT = 8'hE0;
	localparam logic [7:0]  LEAD3_MSK = 8'hF0;
	localparam logic [7:0]  LEAD2_PAT = 8'hC0;
	localparam logic [7:0]  LEAD2_MSK = 8'hE0;
	localparam logic [7:0]  CONT_MSK  = 8'h3F;

	localparam logic [1:0]  SEQ_LEN2  = 2'd2;
	localparam logic [1:0]  SEQ_LEN3  = 2'd3;

	localparam int          QUEUE_AW    = 2;
	localparam int          QUEUE_DEPTH = 1 << QUEUE_AW;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       error;
		logic       out_last;
	} u2k_res_t;

endpackage

// ===== hdl/u2k_if.sv =====
// Stream interfaces for the converter's input bytes and result bytes.
interface u2k_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface u2k_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       error;
	logic       out_last;

	modport source (output valid, output out_byte, output error, output out_last, input ready);
	modport sink (input valid, input out_byte, input error, input out_last, output ready);
endinterface

// ===== hdl/u2k_core.sv =====
// Sequence decoder: held-sequence state and per-byte result generation.
module u2k_core
	import u2k_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic [1:0] res_n,
	output u2k_res_t   res0,
	output u2k_res_t   res1
);

	logic [7:0]  lead_q, second_q;
	logic [1:0]  held_q, needed_q;
	logic        dropping_q;

	logic [7:0]  lead_d, second_d;
	logic [1:0]  held_d, needed_d;
	logic        dropping_d;

	logic [15:0] cp3, val3;
	logic [10:0] cp2;
	logic        ok3, ok2, ok;
	logic [7:0]  val;

	assign cp3  = {lead_q[3:0], second_q[5:0], in_byte[5:0]};
	assign ok3  = (cp3 >= KANA_LO) && (cp3 <= KANA_HI);
	assign val3 = cp3 - KANA_BASE;
	assign cp2  = {lead_q[4:0], in_byte[5:0]};
	assign ok2  = (cp2[10:8] == 3'd0);
	assign ok   = (needed_q == SEQ_LEN3) ? ok3 : ok2;
	assign val  = (needed_q == SEQ_LEN3) ? val3[7:0] : cp2[7:0];

	always_comb begin
		lead_d     = lead_q;
		second_d   = second_q;
		held_d     = held_q;
		needed_d   = needed_q;
		dropping_d = dropping_q;
		res_n      = 2'd0;
		res0       = '{out_byte: in_byte, error: 1'b0, out_last: in_last};
		res1       = '{out_byte: in_byte, error: 1'b0, out_last: 1'b1};
		if (dropping_q) begin
			if (in_last) begin
				dropping_d = 1'b0;
			end
		end else if (held_q == 2'd0) begin
			if (in_byte[7] && !in_last && ((in_byte & LEAD3_MSK) == LEAD3_PAT)) begin
				lead_d   = in_byte;
				held_d   = 2'd1;
				needed_d = SEQ_LEN3;
			end else if (in_byte[7] && !in_last && ((in_byte & LEAD2_MSK) == LEAD2_PAT)) begin
				lead_d   = in_byte;
				held_d   = 2'd1;
				needed_d = SEQ_LEN2;
			end else begin
				res_n = 2'd1;
			end
		end else if (needed_q == SEQ_LEN3 && held_q == 2'd1) begin
			if (!in_last) begin
				second_d = in_byte;
				held_d   = 2'd2;
			end else begin
				res_n    = 2'd2;
				res0     = '{out_byte: lead_q, error: 1'b0, out_last: 1'b0};
				lead_d   = 8'd0;
				second_d = 8'd0;
				held_d   = 2'd0;
				needed_d = 2'd0;
			end
		end else begin
			res_n    = 2'd1;
			lead_d   = 8'd0;
			second_d = 8'd0;
			held_d   = 2'd0;
			needed_d = 2'd0;
			if (ok) begin
				res0 = '{out_byte: val, error: 1'b0, out_last: in_last};
			end else begin
				res0       = '{out_byte: 8'd0, error: 1'b1, out_last: 1'b1};
				dropping_d = !in_last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q     <= 8'd0;
			second_q   <= 8'd0;
			held_q     <= 2'd0;
			needed_q   <= 2'd0;
			dropping_q <= 1'b0;
		end else if (fire) begin
			lead_q     <= lead_d;
			second_q   <= second_d;
			held_q     <= held_d;
			needed_q   <= needed_d;
			dropping_q <= dropping_d;
		end
	end

endmodule

// ===== hdl/u2k_queue.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle on each pop.
module u2k_queue
	import u2k_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  u2k_res_t   din0,
	input  u2k_res_t   din1,
	input  logic       pop,
	output u2k_res_t   dout,
	output logic       not_empty,
	output logic       room2
);

	u2k_res_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wp_q, rp_q;
	logic [QUEUE_AW:0]     cnt_q;
	logic [QUEUE_AW-1:0]   wp_nx;

	assign wp_nx     = wp_q + QUEUE_AW'(1);
	assign dout      = mem_q[rp_q];
	assign not_empty = (cnt_q != '0);
	assign room2     = (cnt_q <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wp_q] <= din0;
		end
		if (push_n == 2'd2) begin
			mem_q[wp_nx] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QUEUE_AW'(push_n);
			if (pop) begin
				rp_q <= rp_q + QUEUE_AW'(1);
			end
			cnt_q <= cnt_q + (QUEUE_AW+1)'(push_n) - (QUEUE_AW+1)'(pop);
		end
	end

endmodule

// ===== hdl/utf8_to_single_byte_kana_top.sv =====
// Top level of the UTF-8 to single-byte kana converter.
// Takes one UTF-8 byte per cycle and produces results into a four-entry queue;
// a byte is decoded in the cycle it is accepted, and its result can be taken on
// the next cycle. Input is ready whenever the queue has room for two results, so
// with the output side taking one result per cycle the block sustains one byte
// per cycle; a string cut short after a 3-byte lead and one more byte gives two
// results, which the queue absorbs.
module utf8_to_single_byte_kana_top
	import u2k_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	u2k_in_if.sink    in_ch,
	u2k_out_if.source out_ch
);

	logic       fire;
	logic [1:0] res_n;
	u2k_res_t   res0, res1, head;
	logic       not_empty, room2;

	assign in_ch.ready = room2;
	assign fire        = in_ch.valid && room2;

	u2k_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.in_byte (in_ch.in_byte),
		.in_last (in_ch.in_last),
		.res_n   (res_n),
		.res0    (res0),
		.res1    (res1)
	);

	u2k_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (fire ? res_n : 2'd0),
		.din0      (res0),
		.din1      (res1),
		.pop       (out_ch.valid && out_ch.ready),
		.dout      (head),
		.not_empty (not_empty),
		.room2     (room2)
	);

	assign out_ch.valid    = not_empty;
	assign out_ch.out_byte = head.out_byte;
	assign out_ch.error    = head.error;
	assign out_ch.out_last = head.out_last;

endmodule
